>>> sv/glm_pkg.sv
// Shared types and constants for the group label merge block.
package glm_pkg;

    localparam int ENTRIES_DEF     = 4096;
    localparam int MAX_MEMBERS_DEF = 256;

    localparam int ID_W     = 12;
    localparam int LABEL_W  = 13;
    localparam int DCOUNT_W = 9;

    // Label space covers every 13-bit label value
    localparam int LBL_DEPTH = 1 << LABEL_W;

    typedef logic [ID_W-1:0]     id_t;
    typedef logic [LABEL_W-1:0]  label_t;
    typedef logic [DCOUNT_W-1:0] dcount_t;

    localparam label_t LABEL_MAX = {LABEL_W{1'b1}};

    localparam logic REQ_ADD  = 1'b0;
    localparam logic REQ_READ = 1'b1;

endpackage

>>> sv/glm_if.sv
// Request and response channel interfaces for the group label merge block.
interface glm_req_if;
    logic          valid;
    logic          ready;
    logic          req_type;
    glm_pkg::id_t  entry_id;
    logic          last_member;

    modport source (output valid, output req_type, output entry_id, output last_member,
                    input ready);
    modport sink   (input valid, input req_type, input entry_id, input last_member,
                    output ready);
endinterface

interface glm_rsp_if;
    logic             valid;
    logic             ready;
    glm_pkg::label_t  label;
    glm_pkg::dcount_t distinct_count;
    logic             overflow;

    modport source (output valid, output label, output distinct_count, output overflow,
                    input ready);
    modport sink   (input valid, input label, input distinct_count, input overflow,
                    output ready);
endinterface

>>> sv/group_label_merge.sv
// Group label merge: a label table with set gathering, merge sweep and label reads.
//
// After reset the block clears its label table and its label-seen bitmap before
// req.ready first rises. A member transfer that does not close its set leaves the
// block ready for the next member. A read loads the table word, then the output
// register, before its result is offered. Closing a set of buffered members
// gathers their distinct labels, relabels the members and, when two or more were
// found, sweeps the entries in use; the gather, relabel and sweep use the table in turn.
// A finished result sits in an output register while new members are taken.
module group_label_merge #(
    parameter int ENTRIES     = glm_pkg::ENTRIES_DEF,
    parameter int MAX_MEMBERS = glm_pkg::MAX_MEMBERS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  glm_pkg::label_t     cfg_wdata,
    glm_req_if.sink             req,
    glm_rsp_if.source           rsp
);
    import glm_pkg::*;

    localparam int TW    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int MW    = (MAX_MEMBERS > 1) ? $clog2(MAX_MEMBERS) : 1;
    localparam int CW    = $clog2(MAX_MEMBERS + 1);
    localparam int CLR_N = (ENTRIES > LBL_DEPTH) ? ENTRIES : LBL_DEPTH;
    localparam int SWW   = $clog2(CLR_N + 1);
    localparam int RANGE_W = 18;

    localparam logic [3:0] S_INIT = 4'd0;
    localparam logic [3:0] S_IDLE = 4'd1;
    localparam logic [3:0] S_G0   = 4'd2;
    localparam logic [3:0] S_G1   = 4'd3;
    localparam logic [3:0] S_G2   = 4'd4;
    localparam logic [3:0] S_G3   = 4'd5;
    localparam logic [3:0] S_PICK = 4'd6;
    localparam logic [3:0] S_L0   = 4'd7;
    localparam logic [3:0] S_L1   = 4'd8;
    localparam logic [3:0] S_S0   = 4'd9;
    localparam logic [3:0] S_S1   = 4'd10;
    localparam logic [3:0] S_S2   = 4'd11;
    localparam logic [3:0] S_C0   = 4'd12;
    localparam logic [3:0] S_C1   = 4'd13;
    localparam logic [3:0] S_DONE = 4'd14;

    // Memories
    label_t tbl_mem  [ENTRIES];
    id_t    mbuf_mem [MAX_MEMBERS];
    label_t dlist_mem[MAX_MEMBERS];
    logic   seen_mem [LBL_DEPTH];

    logic            tb_we, tb_re;
    logic [TW-1:0]   tb_waddr, tb_raddr;
    label_t          tb_wdata, tb_rdata_reg;
    logic            mb_we, mb_re;
    logic [MW-1:0]   mb_waddr, mb_raddr;
    id_t             mb_wdata, mb_rdata_reg;
    logic            dl_we, dl_re;
    logic [MW-1:0]   dl_waddr, dl_raddr;
    label_t          dl_wdata, dl_rdata_reg;
    logic            sn_we, sn_re;
    label_t          sn_waddr, sn_raddr;
    logic            sn_wdata, sn_rdata_reg;

    logic [3:0]      state_reg, state_next;
    label_t          eiu_reg, eiu_next;
    label_t          next_label_reg, next_label_next;
    logic [CW-1:0]   mcount_reg, mcount_next;
    logic            ovf_reg, ovf_next;
    logic [CW-1:0]   idx_reg, idx_next;
    logic [SWW-1:0]  sweep_reg, sweep_next;
    logic [CW-1:0]   n_reg, n_next;
    label_t          last_dist_reg, last_dist_next;
    label_t          lab_reg, lab_next;
    logic            is_read_reg, is_read_next;
    logic            rd_zero_reg, rd_zero_next;
    logic            out_valid_reg, out_valid_next;
    label_t          out_label_reg, out_label_next;
    dcount_t         out_cnt_reg, out_cnt_next;
    logic            out_ovf_reg, out_ovf_next;

    logic            accept, id_in_range;
    logic [SWW-1:0]  limit;
    logic [CW-1:0]   idx_inc;
    logic [SWW-1:0]  sweep_inc;

    assign req.ready          = (state_reg == S_IDLE);
    assign rsp.valid          = out_valid_reg;
    assign rsp.label          = out_label_reg;
    assign rsp.distinct_count = out_cnt_reg;
    assign rsp.overflow       = out_ovf_reg;

    assign accept      = req.valid & req.ready;
    assign id_in_range = RANGE_W'(req.entry_id) < RANGE_W'(ENTRIES);
    assign limit       = (SWW'(eiu_reg) < SWW'(ENTRIES)) ? SWW'(eiu_reg) : SWW'(ENTRIES);
    assign idx_inc     = CW'(idx_reg + 1'b1);
    assign sweep_inc   = SWW'(sweep_reg + 1'b1);

    always_ff @(posedge clk)
    begin
        if (tb_we)
        begin
            tbl_mem[tb_waddr] <= tb_wdata;
        end
        if (tb_re)
        begin
            tb_rdata_reg <= tbl_mem[tb_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (mb_we)
        begin
            mbuf_mem[mb_waddr] <= mb_wdata;
        end
        if (mb_re)
        begin
            mb_rdata_reg <= mbuf_mem[mb_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (dl_we)
        begin
            dlist_mem[dl_waddr] <= dl_wdata;
        end
        if (dl_re)
        begin
            dl_rdata_reg <= dlist_mem[dl_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (sn_we)
        begin
            seen_mem[sn_waddr] <= sn_wdata;
        end
        if (sn_re)
        begin
            sn_rdata_reg <= seen_mem[sn_raddr];
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        eiu_next        = eiu_reg;
        next_label_next = next_label_reg;
        mcount_next     = mcount_reg;
        ovf_next        = ovf_reg;
        idx_next        = idx_reg;
        sweep_next      = sweep_reg;
        n_next          = n_reg;
        last_dist_next  = last_dist_reg;
        lab_next        = lab_reg;
        is_read_next    = is_read_reg;
        rd_zero_next    = rd_zero_reg;
        out_valid_next  = out_valid_reg;
        out_label_next  = out_label_reg;
        out_cnt_next    = out_cnt_reg;
        out_ovf_next    = out_ovf_reg;

        tb_we = 1'b0; tb_re = 1'b0; tb_waddr = '0; tb_raddr = '0; tb_wdata = '0;
        mb_we = 1'b0; mb_re = 1'b0; mb_waddr = '0; mb_raddr = '0; mb_wdata = '0;
        dl_we = 1'b0; dl_re = 1'b0; dl_waddr = '0; dl_raddr = '0; dl_wdata = '0;
        sn_we = 1'b0; sn_re = 1'b0; sn_waddr = '0; sn_raddr = '0; sn_wdata = 1'b0;

        if (out_valid_reg && rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
        if (cfg_we)
        begin
            eiu_next = cfg_wdata;
        end

        case (state_reg)
            S_INIT:
            begin
                // Clear table and bitmap, one address a cycle
                tb_we    = (RANGE_W'(sweep_reg) < RANGE_W'(ENTRIES));
                tb_waddr = sweep_reg[TW-1:0];
                sn_we    = (RANGE_W'(sweep_reg) < RANGE_W'(LBL_DEPTH));
                sn_waddr = sweep_reg[LABEL_W-1:0];
                if (sweep_inc == SWW'(CLR_N))
                begin
                    sweep_next = '0;
                    state_next = S_IDLE;
                end
                else
                begin
                    sweep_next = sweep_inc;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    if (req.req_type == REQ_READ)
                    begin
                        is_read_next = 1'b1;
                        rd_zero_next = !id_in_range;
                        tb_re        = 1'b1;
                        tb_raddr     = TW'(req.entry_id);
                        state_next   = S_DONE;
                    end
                    else
                    begin
                        is_read_next = 1'b0;
                        if (id_in_range)
                        begin
                            if (RANGE_W'(mcount_reg) < RANGE_W'(MAX_MEMBERS))
                            begin
                                mb_we       = 1'b1;
                                mb_waddr    = mcount_reg[MW-1:0];
                                mb_wdata    = req.entry_id;
                                mcount_next = CW'(mcount_reg + 1'b1);
                            end
                            else
                            begin
                                ovf_next = 1'b1;
                            end
                        end
                        if (req.last_member)
                        begin
                            idx_next   = '0;
                            n_next     = '0;
                            state_next = (mcount_next == '0) ? S_PICK : S_G0;
                        end
                    end
                end
            end
            S_G0:
            begin
                mb_re      = 1'b1;
                mb_raddr   = idx_reg[MW-1:0];
                state_next = S_G1;
            end
            S_G1:
            begin
                tb_re      = 1'b1;
                tb_raddr   = TW'(mb_rdata_reg);
                state_next = S_G2;
            end
            S_G2:
            begin
                sn_re      = 1'b1;
                sn_raddr   = tb_rdata_reg;
                state_next = S_G3;
            end
            S_G3:
            begin
                // Append a nonzero label not yet seen in this set
                if (tb_rdata_reg != '0 && !sn_rdata_reg)
                begin
                    sn_we          = 1'b1;
                    sn_waddr       = tb_rdata_reg;
                    sn_wdata       = 1'b1;
                    dl_we          = 1'b1;
                    dl_waddr       = n_reg[MW-1:0];
                    dl_wdata       = tb_rdata_reg;
                    n_next         = CW'(n_reg + 1'b1);
                    last_dist_next = tb_rdata_reg;
                end
                idx_next   = idx_inc;
                state_next = (idx_inc == mcount_reg) ? S_PICK : S_G0;
            end
            S_PICK:
            begin
                if (n_reg == '0)
                begin
                    lab_next = next_label_reg;
                    if (next_label_reg != LABEL_MAX)
                    begin
                        next_label_next = label_t'(next_label_reg + 1'b1);
                    end
                end
                else
                begin
                    lab_next = last_dist_reg;
                end
                idx_next   = '0;
                state_next = (mcount_reg == '0) ? S_DONE : S_L0;
            end
            S_L0:
            begin
                mb_re      = 1'b1;
                mb_raddr   = idx_reg[MW-1:0];
                state_next = S_L1;
            end
            S_L1:
            begin
                tb_we    = 1'b1;
                tb_waddr = TW'(mb_rdata_reg);
                tb_wdata = lab_reg;
                idx_next = idx_inc;
                if (idx_inc == mcount_reg)
                begin
                    idx_next   = '0;
                    sweep_next = '0;
                    if (n_reg > CW'(1) && limit != '0)
                    begin
                        state_next = S_S0;
                    end
                    else if (n_reg != '0)
                    begin
                        state_next = S_C0;
                    end
                    else
                    begin
                        state_next = S_DONE;
                    end
                end
                else
                begin
                    state_next = S_L0;
                end
            end
            S_S0:
            begin
                tb_re      = 1'b1;
                tb_raddr   = sweep_reg[TW-1:0];
                state_next = S_S1;
            end
            S_S1:
            begin
                sn_re      = 1'b1;
                sn_raddr   = tb_rdata_reg;
                state_next = S_S2;
            end
            S_S2:
            begin
                // Relabel entries that carry one of the merged labels
                if (sn_rdata_reg && tb_rdata_reg != lab_reg)
                begin
                    tb_we    = 1'b1;
                    tb_waddr = sweep_reg[TW-1:0];
                    tb_wdata = lab_reg;
                end
                sweep_next = sweep_inc;
                state_next = (sweep_inc == limit) ? S_C0 : S_S0;
            end
            S_C0:
            begin
                dl_re      = 1'b1;
                dl_raddr   = idx_reg[MW-1:0];
                state_next = S_C1;
            end
            S_C1:
            begin
                // Drop the seen marks of this set
                sn_we      = 1'b1;
                sn_waddr   = dl_rdata_reg;
                sn_wdata   = 1'b0;
                idx_next   = idx_inc;
                state_next = (idx_inc == n_reg) ? S_DONE : S_C0;
            end
            S_DONE:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next = 1'b1;
                    if (is_read_reg)
                    begin
                        out_label_next = rd_zero_reg ? '0 : tb_rdata_reg;
                        out_cnt_next   = '0;
                        out_ovf_next   = 1'b0;
                    end
                    else
                    begin
                        out_label_next = lab_reg;
                        out_cnt_next   = dcount_t'(n_reg);
                        out_ovf_next   = ovf_reg;
                        mcount_next    = '0;
                        ovf_next       = 1'b0;
                    end
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_INIT;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_INIT;
            eiu_reg        <= label_t'(ENTRIES);
            next_label_reg <= label_t'(1);
            mcount_reg     <= '0;
            ovf_reg        <= 1'b0;
            idx_reg        <= '0;
            sweep_reg      <= '0;
            n_reg          <= '0;
            is_read_reg    <= 1'b0;
            rd_zero_reg    <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            eiu_reg        <= eiu_next;
            next_label_reg <= next_label_next;
            mcount_reg     <= mcount_next;
            ovf_reg        <= ovf_next;
            idx_reg        <= idx_next;
            sweep_reg      <= sweep_next;
            n_reg          <= n_next;
            is_read_reg    <= is_read_next;
            rd_zero_reg    <= rd_zero_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        last_dist_reg <= last_dist_next;
        lab_reg       <= lab_next;
        out_label_reg <= out_label_next;
        out_cnt_reg   <= out_cnt_next;
        out_ovf_reg   <= out_ovf_next;
    end

endmodule

>>> sv/glm_checker.sv
// Port-level checks for the group label merge block, bound to its top level.
module glm_checker (
    input logic            clk,
    input logic            rst_n,
    input logic            in_valid,
    input logic            in_ready,
    input logic            in_req_type,
    input logic            in_last,
    input logic            out_valid,
    input logic            out_ready,
    input glm_pkg::label_t out_label,
    input glm_pkg::dcount_t out_count,
    input logic            out_overflow
);
    import glm_pkg::*;

    // A held result keeps its label
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_label))
        else $error("result changed while stalled");

    // A member that does not close its set makes no result
    a_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && in_req_type == REQ_ADD && !in_last && !out_valid
        |=> !out_valid)
        else $error("result without close or read");

    // Reads and closes occupy the block
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (in_req_type == REQ_READ || in_last) |=> !in_ready)
        else $error("ready right after read or close");

    // Label zero only comes from a read, which carries no count or flag
    a_zero_label: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_label == '0 |-> out_count == '0 && !out_overflow)
        else $error("closed set got label zero");

endmodule

bind group_label_merge glm_checker u_glm_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (req.valid),
    .in_ready     (req.ready),
    .in_req_type  (req.req_type),
    .in_last      (req.last_member),
    .out_valid    (rsp.valid),
    .out_ready    (rsp.ready),
    .out_label    (rsp.label),
    .out_count    (rsp.distinct_count),
    .out_overflow (rsp.overflow)
);
